// File: rtl/bsu_pkg.sv
package bsu_pkg;

  // how the enclosing sphere was formed
  typedef enum logic [1:0] {
    OUT_FIRST     = 2'd0,
    OUT_SECOND    = 2'd1,
    OUT_MERGED    = 2'd2,
    OUT_SATURATED = 2'd3
  } outcome_t;

endpackage

// File: rtl/bsu_sqrt.sv
module bsu_sqrt #(
  parameter int IN_W  = 66,
  parameter int TAG_W = 8,
  localparam int ROOT_W = (IN_W + 1) / 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   in_x,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output logic [TAG_W-1:0]  out_tag
);

  localparam int TW = 2 * ROOT_W + 1;

  // one root bit per stage, remainder kept as x - root^2
  logic              vld_q  [ROOT_W];
  logic [IN_W-1:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [TAG_W-1:0]  tag_q  [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int B = ROOT_W - 1 - s;
    logic              v_in;
    logic [IN_W-1:0]   rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [TAG_W-1:0]  tag_in;
    logic [TW-1:0]     trial;
    logic              take;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_x;
      assign root_in = '0;
      assign tag_in  = in_tag;
    end else begin : g_next
      assign v_in    = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign tag_in  = tag_q[s-1];
    end

    assign trial = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));
    assign take  = TW'(rem_in) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]  <= take ? IN_W'(TW'(rem_in) - trial) : rem_in;
        root_q[s] <= take ? (root_in | (ROOT_W'(1) << B)) : root_in;
        tag_q[s]  <= tag_in;
      end
    end
  end

  // round to nearest: x > r^2 + r means the upper neighbor is closer
  logic round_up;
  assign round_up = IN_W'(root_q[ROOT_W-1]) < rem_q[ROOT_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_q[ROOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_root <= root_q[ROOT_W-1] + ROOT_W'(round_up);
      out_tag  <= tag_q[ROOT_W-1];
    end
  end

endmodule

// File: rtl/bsu_div.sv
module bsu_div #(
  parameter int NUM_W = 66,
  parameter int DIV_W = 34,
  parameter int Q_W   = 32,
  parameter int LANES = 3,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num [LANES],
  input  logic [DIV_W-1:0] in_div,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [Q_W-1:0]   out_quo [LANES],
  output logic [TAG_W-1:0] out_tag
);

  // restoring division, one quotient bit per stage; the low numerator bits
  // shift out of lo_q while quotient bits shift in behind them
  logic             vld_q [Q_W];
  logic [DIV_W-1:0] div_q [Q_W];
  logic [TAG_W-1:0] tag_q [Q_W];
  logic [DIV_W-1:0] rem_q [Q_W][LANES];
  logic [Q_W-1:0]   lo_q  [Q_W][LANES];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic             v_in;
    logic [DIV_W-1:0] div_in;
    logic [TAG_W-1:0] tag_in;

    if (s == 0) begin : g_first
      assign v_in   = in_valid;
      assign div_in = in_div;
      assign tag_in = in_tag;
    end else begin : g_next
      assign v_in   = vld_q[s-1];
      assign div_in = div_q[s-1];
      assign tag_in = tag_q[s-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_q[s] <= div_in;
        tag_q[s] <= tag_in;
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DIV_W-1:0] rem_in;
      logic [Q_W-1:0]   lo_in;
      logic [DIV_W:0]   rem2;
      logic             ge;

      if (s == 0) begin : g_first
        assign rem_in = DIV_W'(in_num[l] >> Q_W);
        assign lo_in  = in_num[l][Q_W-1:0];
      end else begin : g_next
        assign rem_in = rem_q[s-1][l];
        assign lo_in  = lo_q[s-1][l];
      end

      assign rem2 = {rem_in, lo_in[Q_W-1]};
      assign ge   = rem2 >= {1'b0, div_in};

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[s][l] <= ge ? DIV_W'(rem2 - {1'b0, div_in}) : rem2[DIV_W-1:0];
          lo_q[s][l]  <= {lo_in[Q_W-2:0], ge};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_q[Q_W-1];
    end
  end

  // round half up: twice the remainder against the divisor
  for (genvar l = 0; l < LANES; l++) begin : g_out
    logic round_up;
    assign round_up = {rem_q[Q_W-1][l], 1'b0} >= {1'b0, div_q[Q_W-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        out_quo[l] <= lo_q[Q_W-1][l] + Q_W'(round_up);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag <= tag_q[Q_W-1];
    end
  end

endmodule

// File: rtl/bounding_sphere_union.sv
// Smallest sphere enclosing two spheres, centers and radii in Q16.16 style
// fixed point (COORD_BITS wide, radii one bit narrower and unsigned). One
// transfer in and one result transfer out per item, in order. The block is
// a straight pipeline and takes a new item every cycle while the skid entry
// is empty; its depth comes mostly from the bit-per-stage square root
// (COORD_BITS+2 stages) and the bit-per-stage divider for the center
// offset (COORD_BITS+1 stages). A two-entry output buffer lets the input
// keep flowing while a result waits, until a second result parks in the
// skid entry; that stalls the whole pipeline. Reset is synchronous and
// clears only the valid bits.
module bounding_sphere_union
  import bsu_pkg::*;
#(
  parameter int COORD_BITS = 32,
  localparam int IN_W  = ((8 * COORD_BITS - 2 + 7) / 8) * 8,
  localparam int OUT_W = ((4 * COORD_BITS - 1 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // low to high: first_x, first_y, first_z, first_radius,
  // second_x, second_y, second_z, second_radius, zero pad
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  // low to high: merged_x, merged_y, merged_z, merged_radius, zero pad
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  // outcome
  output logic [1:0]       m_tuser
);

  localparam int C      = COORD_BITS;
  localparam int R_W    = C - 1;
  localparam int D2_W   = 2 * C + 2;
  localparam int D_W    = C + 1;
  localparam int NUMF_W = C + 3;
  localparam int PROD_W = 2 * C + 2;
  localparam int OUT_PAD = OUT_W - (4 * C - 1);

  // side data riding along the square root
  typedef struct packed {
    logic              cont;
    logic              second;
    logic [2:0][C-1:0] base;
    logic [R_W-1:0]    base_r;
    logic [2:0][C-1:0] mag;
    logic [2:0]        neg;
    logic [C-1:0]      rdiff;
    logic [C-1:0]      rsum;
  } sq_tag_t;

  // side data riding along the divider
  typedef struct packed {
    logic              bypass;
    outcome_t          outc;
    logic [2:0][C-1:0] base;
    logic [2:0]        neg;
    logic [R_W-1:0]    rad;
  } dv_tag_t;

  typedef struct packed {
    outcome_t          outc;
    logic [R_W-1:0]    r;
    logic [2:0][C-1:0] c;
  } res_t;

  // the whole pipeline moves while the skid entry is empty
  logic en;
  logic skid_valid;
  assign en       = !skid_valid;
  assign s_tready = en;

  // ---------------------------------------------------------------- stage 1
  // unpack, center differences and their magnitudes, radius difference
  logic [2:0][C-1:0] in_c1, in_c2, in_mag;
  logic [2:0]        in_neg;
  logic [C:0]        in_diff [3];
  logic [R_W-1:0]    in_r1, in_r2, in_absrd;
  logic [C-1:0]      in_rdiff;
  logic              in_rpos;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_c1[i]   = s_tdata[i*C +: C];
      in_c2[i]   = s_tdata[4*C-1 + i*C +: C];
      in_diff[i] = {in_c2[i][C-1], in_c2[i]} - {in_c1[i][C-1], in_c1[i]};
      in_neg[i]  = in_diff[i][C];
      in_mag[i]  = in_neg[i] ? C'(-in_diff[i]) : in_diff[i][C-1:0];
    end
    in_r1    = s_tdata[3*C +: R_W];
    in_r2    = s_tdata[7*C-1 +: R_W];
    in_rdiff = {1'b0, in_r2} - {1'b0, in_r1};
    in_absrd = in_rdiff[C-1] ? R_W'(-in_rdiff) : in_rdiff[R_W-1:0];
    in_rpos  = !in_rdiff[C-1] && (in_rdiff != '0);
  end

  logic              p1_v;
  logic [2:0][C-1:0] p1_c1, p1_c2, p1_mag;
  logic [2:0]        p1_neg;
  logic [R_W-1:0]    p1_r1, p1_r2, p1_absrd;
  logic [C-1:0]      p1_rdiff;
  logic              p1_rpos;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else if (en) begin
      p1_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_c1    <= in_c1;
      p1_c2    <= in_c2;
      p1_mag   <= in_mag;
      p1_neg   <= in_neg;
      p1_r1    <= in_r1;
      p1_r2    <= in_r2;
      p1_absrd <= in_absrd;
      p1_rdiff <= in_rdiff;
      p1_rpos  <= in_rpos;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // squares of the differences
  logic                p2_v;
  logic [2*C-1:0]      p2_sq [3];
  logic [2*R_W-1:0]    p2_rsq;
  logic [2:0][C-1:0]   p2_c1, p2_c2, p2_mag;
  logic [2:0]          p2_neg;
  logic [R_W-1:0]      p2_r1, p2_r2;
  logic [C-1:0]        p2_rdiff;
  logic                p2_rpos;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
    end else if (en) begin
      p2_v <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p2_sq[i] <= p1_mag[i] * p1_mag[i];
      end
      p2_rsq   <= p1_absrd * p1_absrd;
      p2_c1    <= p1_c1;
      p2_c2    <= p1_c2;
      p2_mag   <= p1_mag;
      p2_neg   <= p1_neg;
      p2_r1    <= p1_r1;
      p2_r2    <= p1_r2;
      p2_rdiff <= p1_rdiff;
      p2_rpos  <= p1_rpos;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // squared distance and the containment test; pick the sphere to pass on
  logic [D2_W-1:0] p2_d2;
  logic            p2_cont, p2_second;
  sq_tag_t         p2_tag;

  always_comb begin
    p2_d2     = D2_W'(p2_sq[0]) + D2_W'(p2_sq[1]) + D2_W'(p2_sq[2]);
    p2_cont   = p2_d2 <= D2_W'(p2_rsq);
    p2_second = p2_cont && p2_rpos;
    p2_tag.cont   = p2_cont;
    p2_tag.second = p2_second;
    p2_tag.base   = p2_second ? p2_c2 : p2_c1;
    p2_tag.base_r = p2_second ? p2_r2 : p2_r1;
    p2_tag.mag    = p2_mag;
    p2_tag.neg    = p2_neg;
    p2_tag.rdiff  = p2_rdiff;
    p2_tag.rsum   = C'(p2_r1) + C'(p2_r2);
  end

  logic            p3_v;
  logic [D2_W-1:0] p3_d2;
  sq_tag_t         p3_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_v <= 1'b0;
    end else if (en) begin
      p3_v <= p2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_d2  <= p2_d2;
      p3_tag <= p2_tag;
    end
  end

  // ------------------------------------------------------------ square root
  logic           sq_v;
  logic [D_W-1:0] sq_d;
  sq_tag_t        sq_tag;

  bsu_sqrt #(
    .IN_W  (D2_W),
    .TAG_W ($bits(sq_tag_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p3_v),
    .in_x      (p3_d2),
    .in_tag    (p3_tag),
    .out_valid (sq_v),
    .out_root  (sq_d),
    .out_tag   (sq_tag)
  );

  // ---------------------------------------------------------------- stage 4
  // offset numerator d + rdiff, divisor 2d, merged radius with saturation
  logic [NUMF_W-1:0] sq_numf_s, sq_numf;
  logic [C+1:0]      sq_total;
  logic [C:0]        sq_half;
  logic              sq_sat, sq_bypass;
  dv_tag_t           sq_dtag;

  always_comb begin
    sq_numf_s = NUMF_W'({1'b0, sq_d})
              + {{(NUMF_W-C){sq_tag.rdiff[C-1]}}, sq_tag.rdiff};
    sq_numf   = sq_numf_s[NUMF_W-1] ? '0 : sq_numf_s;
    sq_total  = (C+2)'(sq_d) + (C+2)'(sq_tag.rsum) + (C+2)'(1);
    sq_half   = sq_total[C+1:1];
    sq_sat    = |sq_half[C:C-1];
    // zero distance cannot follow a failed containment test, but is covered
    sq_bypass = sq_tag.cont || (sq_d == '0);
    sq_dtag.bypass = sq_bypass;
    sq_dtag.base   = sq_tag.base;
    sq_dtag.neg    = sq_tag.neg;
    if (sq_bypass) begin
      sq_dtag.outc = sq_tag.second ? OUT_SECOND : OUT_FIRST;
      sq_dtag.rad  = sq_tag.base_r;
    end else if (sq_sat) begin
      sq_dtag.outc = OUT_SATURATED;
      sq_dtag.rad  = '1;
    end else begin
      sq_dtag.outc = OUT_MERGED;
      sq_dtag.rad  = sq_half[R_W-1:0];
    end
  end

  logic              p4_v;
  logic [NUMF_W-1:0] p4_numf;
  logic [C+1:0]      p4_div;
  logic [2:0][C-1:0] p4_mag;
  dv_tag_t           p4_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_v <= 1'b0;
    end else if (en) begin
      p4_v <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_numf <= sq_numf;
      p4_div  <= {sq_d, 1'b0};
      p4_mag  <= sq_tag.mag;
      p4_tag  <= sq_dtag;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // |diff| * (d + rdiff) for each axis
  logic              p5_v;
  logic [PROD_W-1:0] p5_prod [3];
  logic [C+1:0]      p5_div;
  dv_tag_t           p5_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      p5_v <= 1'b0;
    end else if (en) begin
      p5_v <= p4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p5_prod[i] <= PROD_W'(p4_mag[i]) * PROD_W'(p4_numf);
      end
      p5_div <= p4_div;
      p5_tag <= p4_tag;
    end
  end

  // ---------------------------------------------------------------- divider
  // offset = |diff| * (d + rdiff) / (2d), rounded half up
  logic         dv_v;
  logic [C-1:0] dv_off [3];
  dv_tag_t      dv_tag;

  bsu_div #(
    .NUM_W (PROD_W),
    .DIV_W (C + 2),
    .Q_W   (C),
    .LANES (3),
    .TAG_W ($bits(dv_tag_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p5_v),
    .in_num    (p5_prod),
    .in_div    (p5_div),
    .in_tag    (p5_tag),
    .out_valid (dv_v),
    .out_quo   (dv_off),
    .out_tag   (dv_tag)
  );

  // -------------------------------------------------------- result assembly
  // the merged center lies between the two centers, so no saturation here
  res_t fin;

  always_comb begin
    fin.outc = dv_tag.outc;
    fin.r    = dv_tag.rad;
    for (int i = 0; i < 3; i++) begin
      if (dv_tag.bypass) begin
        fin.c[i] = dv_tag.base[i];
      end else if (dv_tag.neg[i]) begin
        fin.c[i] = dv_tag.base[i] - dv_off[i];
      end else begin
        fin.c[i] = dv_tag.base[i] + dv_off[i];
      end
    end
  end

  // ------------------------------------------------------ output and skid
  logic out_valid;
  res_t out_q, skid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !m_tready) begin
      // output held: a result leaving the pipeline parks in the skid entry
      if (en && dv_v) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !m_tready) begin
      if (en && dv_v) begin
        skid_q <= fin;
      end
    end else if (skid_valid) begin
      out_q <= skid_q;
    end else begin
      out_q <= fin;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{OUT_PAD{1'b0}}, out_q.r, out_q.c};
  assign m_tuser  = out_q.outc;

endmodule
